FILE: rtl/core/pjq_pkg.sv
// ----------------------------------------------------------------------------
// Priority job queue package
// Shared constants, request and response types and pointer helpers.
// ----------------------------------------------------------------------------
package pjq_pkg;

  localparam int NumLevels  = 4;
  localparam int QueueDepth = 64;
  localparam int IdW        = 16;
  localparam int PrefMax    = 4;
  localparam int QDepth     = 2;

  localparam int LevelW   = $clog2(NumLevels);
  localparam int PtrW     = $clog2(QueueDepth);
  localparam int CntW     = $clog2(QueueDepth + 1);
  localparam int TotW     = $clog2(NumLevels * QueueDepth + 1);
  localparam int AddrW    = $clog2(NumLevels * QueueDepth);
  localparam int JobTotW  = 9;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ActPush        = 2'd0,
    ActPop         = 2'd1,
    ActCountAll    = 2'd2,
    ActCountListed = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] job_id;
    logic [1:0]  job_level;
    logic [7:0]  pref_order;
    logic [2:0]  pref_count;
  } req_t;

  typedef struct packed {
    logic [15:0] out_job_id;
    logic        found;
    logic [8:0]  job_total;
    logic        wake;
    logic        overflow;
  } rsp_t;

  typedef struct packed {
    action_e                        act;
    logic [IdW-1:0]                 id;
    logic                           lvl_ok;
    logic [LevelW-1:0]              lvl;
    logic [PrefMax-1:0]             pref_vld;
    logic [PrefMax-1:0][LevelW-1:0] pref_lvl;
  } op_t;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AddrW-1:0] store_addr(input logic [LevelW-1:0] l,
                                                  input logic [PtrW-1:0]   p);
    return AddrW'(l) * AddrW'(QueueDepth) + AddrW'(p);
  endfunction

endpackage

FILE: rtl/core/pjq_front.sv
// ----------------------------------------------------------------------------
// Priority job queue front end
// Accepts requests, decodes action and preference list, and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module pjq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pjq_pkg::req_t  req_i,
  output logic           op_vld_o,
  output pjq_pkg::op_t   op_o,
  input  logic           op_take_i
);

  pjq_pkg::op_t                    dec;
  pjq_pkg::op_t                    q_mem [pjq_pkg::QDepth];
  logic [pjq_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pjq_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pjq_pkg::QCntW-1:0]       fill_q, fill_d;
  logic [2:0]                      cnt_sat;
  logic                            push, pop;

  always_comb begin
    cnt_sat = (req_i.pref_count > 3'(pjq_pkg::PrefMax)) ? 3'(pjq_pkg::PrefMax)
                                                         : req_i.pref_count;
    dec        = '0;
    dec.act    = pjq_pkg::action_e'(req_i.action);
    dec.id     = pjq_pkg::IdW'(req_i.job_id);
    dec.lvl_ok = int'(req_i.job_level) < pjq_pkg::NumLevels;
    dec.lvl    = pjq_pkg::LevelW'(req_i.job_level);
    for (int k = 0; k < pjq_pkg::PrefMax; k++) begin
      dec.pref_lvl[k] = pjq_pkg::LevelW'(req_i.pref_order[2*k +: 2]);
      dec.pref_vld[k] = (k < int'(cnt_sat)) &&
                        (int'(req_i.pref_order[2*k +: 2]) < pjq_pkg::NumLevels);
    end
  end

  assign busy     = (fill_q == pjq_pkg::QCntW'(pjq_pkg::QDepth));
  assign push     = start && !busy;
  assign op_vld_o = (fill_q != '0);
  assign pop      = op_vld_o && op_take_i;
  assign op_o     = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pjq_pkg::QCntW'(pjq_pkg::QDepth))
    else $error("front queue overfilled");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("front queue fill did not advance");

  a_no_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> !pop)
    else $error("request taken from empty front queue");

endmodule

FILE: rtl/core/pjq_back.sv
// ----------------------------------------------------------------------------
// Priority job queue back end
// Holds per-level FIFO state and job store, executes one request per cycle
// and registers the response.
// ----------------------------------------------------------------------------
module pjq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_vld_i,
  input  pjq_pkg::op_t  op_i,
  output logic          rsp_valid_o,
  output pjq_pkg::rsp_t rsp_o
);

  logic [pjq_pkg::IdW-1:0]    store [pjq_pkg::NumLevels * pjq_pkg::QueueDepth];
  logic [pjq_pkg::IdW-1:0]    rdata_q;

  logic [pjq_pkg::PtrW-1:0]   head_q [pjq_pkg::NumLevels];
  logic [pjq_pkg::PtrW-1:0]   head_d [pjq_pkg::NumLevels];
  logic [pjq_pkg::PtrW-1:0]   tail_q [pjq_pkg::NumLevels];
  logic [pjq_pkg::PtrW-1:0]   tail_d [pjq_pkg::NumLevels];
  logic [pjq_pkg::CntW-1:0]   cnt_q  [pjq_pkg::NumLevels];
  logic [pjq_pkg::CntW-1:0]   cnt_d  [pjq_pkg::NumLevels];
  logic [pjq_pkg::NumLevels-1:0] used_q, used_d;
  logic [pjq_pkg::TotW-1:0]   total_q, total_d;

  logic                       we, re;
  logic [pjq_pkg::AddrW-1:0]  wa, ra;
  logic [pjq_pkg::IdW-1:0]    wd;

  logic                       pop_hit, lst_hit;
  logic [pjq_pkg::LevelW-1:0] pop_lvl, lst_lvl;

  logic                       res_vld_q;
  logic                       res_found_q, found_d;
  logic [pjq_pkg::JobTotW-1:0] res_tot_q, tot_d;
  logic                       res_wake_q, wake_d;
  logic                       res_ovf_q, ovf_d;

  always_comb begin
    pop_hit = 1'b0;
    pop_lvl = '0;
    lst_hit = 1'b0;
    lst_lvl = '0;
    for (int k = pjq_pkg::PrefMax - 1; k >= 0; k--) begin
      if (op_i.pref_vld[k] && (cnt_q[op_i.pref_lvl[k]] != '0)) begin
        pop_hit = 1'b1;
        pop_lvl = op_i.pref_lvl[k];
      end
      if (op_i.pref_vld[k] && used_q[op_i.pref_lvl[k]]) begin
        lst_hit = 1'b1;
        lst_lvl = op_i.pref_lvl[k];
      end
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    used_d  = used_q;
    total_d = total_q;
    we      = 1'b0;
    wa      = '0;
    wd      = op_i.id;
    re      = 1'b0;
    ra      = '0;
    found_d = 1'b0;
    tot_d   = '0;
    wake_d  = 1'b0;
    ovf_d   = 1'b0;
    if (op_vld_i) begin
      case (op_i.act)
        pjq_pkg::ActPush: begin
          if (op_i.lvl_ok) begin
            if (cnt_q[op_i.lvl] == pjq_pkg::CntW'(pjq_pkg::QueueDepth)) begin
              ovf_d = 1'b1;
            end else begin
              we                = 1'b1;
              wa                = pjq_pkg::store_addr(op_i.lvl, tail_q[op_i.lvl]);
              tail_d[op_i.lvl]  = pjq_pkg::ptr_next(tail_q[op_i.lvl]);
              cnt_d[op_i.lvl]   = cnt_q[op_i.lvl] + 1'b1;
              used_d[op_i.lvl]  = 1'b1;
              total_d           = total_q + 1'b1;
              wake_d            = 1'b1;
            end
          end
        end
        pjq_pkg::ActPop: begin
          if (pop_hit) begin
            re              = 1'b1;
            ra              = pjq_pkg::store_addr(pop_lvl, head_q[pop_lvl]);
            head_d[pop_lvl] = pjq_pkg::ptr_next(head_q[pop_lvl]);
            cnt_d[pop_lvl]  = cnt_q[pop_lvl] - 1'b1;
            total_d         = total_q - 1'b1;
            found_d         = 1'b1;
          end
        end
        pjq_pkg::ActCountAll: begin
          tot_d = pjq_pkg::JobTotW'(total_q);
        end
        pjq_pkg::ActCountListed: begin
          if (lst_hit) begin
            tot_d = pjq_pkg::JobTotW'(cnt_q[lst_lvl]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pjq_pkg::NumLevels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      used_q    <= '0;
      total_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      used_q    <= used_d;
      total_q   <= total_d;
      res_vld_q <= op_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= found_d;
    res_tot_q   <= tot_d;
    res_wake_q  <= wake_d;
    res_ovf_q   <= ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store[wa] <= wd;
    end
    if (re) begin
      rdata_q <= store[ra];
    end
  end

  assign rsp_valid_o      = res_vld_q;
  assign rsp_o.out_job_id = res_found_q ? 16'(rdata_q) : '0;
  assign rsp_o.found      = res_found_q;
  assign rsp_o.job_total  = res_tot_q;
  assign rsp_o.wake       = res_wake_q;
  assign rsp_o.overflow   = res_ovf_q;

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(res_wake_q && res_ovf_q) && !(res_found_q && res_wake_q))
    else $error("conflicting response flags");

  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_vld_i |=> $stable(total_q))
    else $error("job total changed without a request");

  a_pop_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_vld_i && (op_i.act == pjq_pkg::ActPop) && pop_hit) |=>
      (res_vld_q && res_found_q))
    else $error("pop hit not reported");

  for (genvar g = 0; g < pjq_pkg::NumLevels; g++) begin : g_chk
    a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q[g] <= pjq_pkg::CntW'(pjq_pkg::QueueDepth)) &&
      ((cnt_q[g] == '0) || used_q[g]))
      else $error("level count out of range");
  end

endmodule

FILE: rtl/core/priority_job_queue.sv
// ----------------------------------------------------------------------------
// Priority job queue
// Strict priority multi-queue of job handles, one FIFO per level.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------
//  request   | start high, busy low   | req_i  (pjq_pkg::req_t)
//  response  | rsp_valid_o, one cycle | rsp_o  (pjq_pkg::rsp_t)
//
//  One request per cycle sustained; the back end executes each request
//  directly against the per-level pointers and the job store.
//  A response strobes once its request has passed the front queue entry
//  and then the back end's response registers.
//  Reset clears pointers, counts and used flags at once; no clearing pass.
//  busy never rises: the back end takes each request the cycle after it is
//  queued, so the two-entry queue between front and back holds at most one.
//  The receiver cannot stall; every response is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module priority_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pjq_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output pjq_pkg::rsp_t rsp_o
);

  logic         op_vld;
  pjq_pkg::op_t op;

  pjq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .op_vld_o  (op_vld),
    .op_o      (op),
    .op_take_i (op_vld)
  );

  pjq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_vld_i    (op_vld),
    .op_i        (op),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: tb/priority_job_queue_test.sv
// ----------------------------------------------------------------------------
// Priority job queue testbench
// Drives push, pop and count requests into the per-level job queue and checks
// each response against a cycle-free model of the level FIFOs, their counts
// and used flags. A directed opening covers the corner cases. Random bursts
// follow: queue fills, drains and mixed traffic, with random sender gaps.
// ----------------------------------------------------------------------------
module priority_job_queue_test;
  import pjq_pkg::*;

  localparam int unsigned NumRequests = 1750;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  class queue_scoreboard;
    logic [IdW-1:0] job_mem [NumLevels][QueueDepth];
    int unsigned    head_idx [NumLevels];
    int unsigned    tail_idx [NumLevels];
    int unsigned    fill [NumLevels];
    bit             ever_used [NumLevels];
    rsp_t           pending_rsp [$];
    int unsigned    errors;

    function new();
      for (int l = 0; l < NumLevels; l++) begin
        head_idx[l]  = 0;
        tail_idx[l]  = 0;
        fill[l]      = 0;
        ever_used[l] = 1'b0;
      end
      errors = 0;
    endfunction

    function rsp_t queue_response(req_t r);
      rsp_t        rsp;
      int unsigned n;
      int unsigned lvl;
      int unsigned sum;
      bit          done;
      rsp  = '0;
      done = 1'b0;
      n    = (r.pref_count > 3'(PrefMax)) ? PrefMax : 32'(r.pref_count);
      case (action_e'(r.action))
        ActPush: begin
          lvl = 32'(r.job_level);
          if (fill[lvl] >= QueueDepth) begin
            rsp.overflow = 1'b1;
          end else begin
            job_mem[lvl][tail_idx[lvl]] = r.job_id;
            tail_idx[lvl] = (tail_idx[lvl] + 1) % QueueDepth;
            fill[lvl]++;
            ever_used[lvl] = 1'b1;
            rsp.wake = 1'b1;
          end
        end
        ActPop: begin
          for (int k = 0; k < n && !done; k++) begin
            lvl = 32'(r.pref_order[2*k +: 2]);
            if (fill[lvl] != 0) begin
              rsp.out_job_id = job_mem[lvl][head_idx[lvl]];
              rsp.found = 1'b1;
              head_idx[lvl] = (head_idx[lvl] + 1) % QueueDepth;
              fill[lvl]--;
              done = 1'b1;
            end
          end
        end
        ActCountAll: begin
          sum = 0;
          for (int l = 0; l < NumLevels; l++) sum += fill[l];
          rsp.job_total = sum[8:0];
        end
        default: begin
          for (int k = 0; k < n && !done; k++) begin
            lvl = 32'(r.pref_order[2*k +: 2]);
            if (ever_used[lvl]) begin
              rsp.job_total = fill[lvl][8:0];
              done = 1'b1;
            end
          end
        end
      endcase
      return rsp;
    endfunction

    function void note_request(req_t r);
      pending_rsp = {pending_rsp, queue_response(r)};
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0h, actual %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: %0h", got);
        errors++;
        return;
      end
      exp = pending_rsp.pop_front();
      compare_field("out_job_id", 32'(exp.out_job_id), 32'(got.out_job_id));
      compare_field("found", 32'(exp.found), 32'(got.found));
      compare_field("job_total", 32'(exp.job_total), 32'(got.job_total));
      compare_field("wake", 32'(exp.wake), 32'(got.wake));
      compare_field("overflow", 32'(exp.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        rsp_valid_o;
  rsp_t        rsp_o;
  int unsigned cycle_count;

  queue_scoreboard board = new();

  priority_job_queue u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_valid_o === 1'b1) board.check_response(rsp_o);
  end

  function automatic req_t make_request(action_e act, logic [1:0] lvl, logic [7:0] order,
                                        logic [2:0] cnt, logic [15:0] id);
    req_t r;
    r.action     = act;
    r.job_level  = lvl;
    r.pref_order = order;
    r.pref_count = cnt;
    r.job_id     = id;
    return r;
  endfunction

  task automatic send_request(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    board.note_request(r);
  endtask

  task automatic hold_off(int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    int unsigned kind;
    int unsigned gap_on;
    logic [1:0]  lvl;
    req_t        r;
    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_request(ActCountAll,    2'd0, 8'h00, 3'd0, 16'h0000));
    send_request(make_request(ActCountListed, 2'd0, 8'hE4, 3'd4, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'hE4, 3'd4, 16'h0000));
    send_request(make_request(ActPush,        2'd0, 8'h00, 3'd0, 16'h0000));
    send_request(make_request(ActPush,        2'd3, 8'hFF, 3'd7, 16'hFFFF));
    send_request(make_request(ActPush,        2'd1, 8'h00, 3'd0, 16'hA5A5));
    send_request(make_request(ActPush,        2'd2, 8'h00, 3'd0, 16'h5A5A));
    send_request(make_request(ActCountListed, 2'd0, 8'hE4, 3'd0, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'hE4, 3'd0, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'hE4, 3'd5, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'h00, 3'd6, 16'h0000));
    send_request(make_request(ActCountListed, 2'd0, 8'h04, 3'd2, 16'h0000));
    send_request(make_request(ActCountListed, 2'd0, 8'h01, 3'd7, 16'h0000));
    send_request(make_request(ActCountAll,    2'd0, 8'h00, 3'd0, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'h1B, 3'd1, 16'h0000));
    send_request(make_request(ActCountListed, 2'd0, 8'hFF, 3'd4, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'hE4, 3'd4, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'hE4, 3'd4, 16'h0000));
    send_request(make_request(ActPop,         2'd0, 8'hE4, 3'd4, 16'h0000));
    send_request(make_request(ActCountAll,    2'd0, 8'h00, 3'd0, 16'h0000));
    wait_drained();

    // fill bursts, drain bursts, mixed traffic; idle during some bursts only
    sent = 0;
    while (sent < NumRequests) begin
      kind   = $urandom_range(0, 9);
      burst  = $urandom_range(4, 80);
      gap_on = $urandom_range(0, 2);
      lvl    = 2'($urandom_range(0, NumLevels - 1));
      for (int unsigned i = 0; i < burst; i++) begin
        r.action     = 2'($urandom_range(0, 3));
        r.job_id     = 16'($urandom_range(0, 65535));
        r.job_level  = 2'($urandom_range(0, NumLevels - 1));
        r.pref_order = 8'($urandom_range(0, 255));
        r.pref_count = 3'($urandom_range(0, 7));
        if (kind < 3) begin
          if ($urandom_range(0, 7) != 0) begin
            r.action    = ActPush;
            r.job_level = lvl;
          end
        end else if (kind < 6) begin
          if ($urandom_range(0, 7) != 0) begin
            r.action = ActPop;
            if ($urandom_range(0, 3) != 0) r.pref_count = 3'(PrefMax);
          end
        end
        hold_off((gap_on != 0) ? $urandom_range(0, 19) : 0);
        send_request(r);
      end
      sent += burst;
      if (kind == 9) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pjq_pkg.sv
rtl/core/pjq_front.sv
rtl/core/pjq_back.sv
rtl/core/priority_job_queue.sv
tb/priority_job_queue_test.sv
